// File: hw/rtl/rtp_receive_depacketizer_top_assert.svh
// Assertion macros shared by the RTP receive depacketizer modules.
// No dependencies; included by the modules that check their own logic.
`ifndef RTP_RECEIVE_DEPACKETIZER_TOP_ASSERT_SVH
`define RTP_RECEIVE_DEPACKETIZER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define RTPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rtpd assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define RTPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtpd assertion failed");

`endif

// File: hw/rtl/rtpd_pkg.sv
// Package for the RTP receive depacketizer: result and config types, codes, limits.
// No dependencies; imported by every module of the block.
package rtpd_pkg;

    // Hard ceiling on the reassembled frame size in bytes.
    localparam logic [20:0] MAX_FRAME_BYTES = 21'd1048576;

    // Result queue depth; input is held off while more than four slots are used.
    localparam int unsigned OQ_DEPTH = 8;
    localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAYLOAD_TYPE    = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_FRAME_LEN   = 2'd2;

    // Packet status codes.
    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_FRAME_DONE  = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_PT_MISMATCH = 3'd3;
    localparam logic [2:0] ST_RTCP        = 3'd4;
    localparam logic [2:0] ST_LENGTH      = 3'd5;
    localparam logic [2:0] ST_SEQ_GAP     = 3'd6;
    localparam logic [2:0] ST_OVERFLOW    = 3'd7;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [6:0]  payload_type;
        logic [15:0] max_payload_len;
        logic [20:0] max_frame_len;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic        frame_restart;
        logic [20:0] frame_length;
        logic [31:0] frame_number;
        logic [15:0] seq_number;
        logic        last;
    } t_result;

    // Up to two results written into the queue in one cycle; valid1 implies valid0.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

// File: hw/rtl/rtpd_cfg_regs.sv
// Configuration registers of the RTP receive depacketizer.
// Depends on rtpd_pkg for the register indexes and the t_cfg type.
module rtpd_cfg_regs
    import rtpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_type    <= 7'd96;
            r_cfg.max_payload_len <= 16'hFFFF;
            r_cfg.max_frame_len   <= 21'd1048576;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAYLOAD_TYPE:    r_cfg.payload_type    <= i_cfg_data[6:0];
                CFG_MAX_PAYLOAD_LEN: r_cfg.max_payload_len <= i_cfg_data[15:0];
                CFG_MAX_FRAME_LEN:   r_cfg.max_frame_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/rtpd_parser.sv
// Header parser, payload forwarding and frame reassembly bookkeeping.
// Depends on rtpd_pkg and on the assertion macros header.
`include "rtp_receive_depacketizer_top_assert.svh"

module rtpd_parser
    import rtpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    // Parse phases.
    localparam logic [2:0] PH_B0   = 3'd0;
    localparam logic [2:0] PH_B1   = 3'd1;
    localparam logic [2:0] PH_FIX  = 3'd2;
    localparam logic [2:0] PH_EXTH = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_PAY  = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_byte_cnt, n_byte_cnt;
    logic [3:0]  r_csrc, n_csrc;
    logic        r_ext, n_ext;
    logic [17:0] r_skip, n_skip;
    logic [15:0] r_cur_seq, n_cur_seq;
    logic        r_cur_marker, n_cur_marker;
    logic [2:0]  r_pkt_status, n_pkt_status;
    logic [16:0] r_pay_cnt, n_pay_cnt;
    logic [15:0] r_prev_seq, n_prev_seq;
    logic        r_prev_marker, n_prev_marker;
    logic        r_sticky, n_sticky;
    logic [20:0] r_frame_fill, n_frame_fill;
    logic [31:0] r_frame_cnt, n_frame_cnt;

    logic [6:0]  hdr_end;
    logic [7:0]  ext_pos;
    logic [17:0] skip_new;
    logic        pay_v;
    logic [20:0] lim;
    logic [20:0] fill0;
    logic [21:0] fill_sum;
    logic        gap;
    logic [2:0]  st;
    logic        rs;
    logic [20:0] fl;
    t_result     pay_res;
    t_result     stat_res;

    // Header end position: twelve fixed bytes plus four per CSRC word, minus one.
    assign hdr_end = {1'b0, r_csrc, 2'b00} + 7'd11;
    assign ext_pos = {1'b0, hdr_end} + 8'd1;
    assign lim     = (i_cfg.max_frame_len < MAX_FRAME_BYTES) ? i_cfg.max_frame_len
                                                               : MAX_FRAME_BYTES;

    // Per-byte parse step, then the end-of-packet decision.
    always_comb begin
        n_phase       = r_phase;
        n_byte_cnt    = r_byte_cnt;
        n_csrc        = r_csrc;
        n_ext         = r_ext;
        n_skip        = r_skip;
        n_cur_seq     = r_cur_seq;
        n_cur_marker  = r_cur_marker;
        n_pkt_status  = r_pkt_status;
        n_pay_cnt     = r_pay_cnt;
        n_prev_seq    = r_prev_seq;
        n_prev_marker = r_prev_marker;
        n_sticky      = r_sticky;
        n_frame_fill  = r_frame_fill;
        n_frame_cnt   = r_frame_cnt;
        skip_new      = {r_skip[17:10], i_byte, 2'b00};
        pay_v         = 1'b0;
        fill0         = r_frame_fill;
        fill_sum      = '0;
        gap           = 1'b0;
        st            = ST_ACCEPTED;
        rs            = 1'b0;
        fl            = '0;

        unique case (r_phase)
            PH_B0: begin
                n_csrc       = i_byte[3:0];
                n_ext        = i_byte[4];
                n_pkt_status = (i_byte[7:6] != 2'b10) ? ST_BAD_VERSION : ST_ACCEPTED;
                n_phase      = PH_B1;
            end
            PH_B1: begin
                n_cur_marker = i_byte[7];
                if (r_pkt_status == ST_ACCEPTED) begin
                    if (i_byte[6:0] != i_cfg.payload_type) begin
                        n_pkt_status = ST_PT_MISMATCH;
                    end else if (i_byte >= 8'd200 && i_byte <= 8'd204) begin
                        n_pkt_status = ST_RTCP;
                    end
                end
                n_phase = PH_FIX;
            end
            PH_FIX: begin
                if (r_byte_cnt == 16'd2) begin
                    n_cur_seq = {i_byte, 8'h00};
                end else if (r_byte_cnt == 16'd3) begin
                    n_cur_seq = {r_cur_seq[15:8], i_byte};
                end
                if (r_byte_cnt >= {9'b0, hdr_end}) begin
                    n_phase = r_ext ? PH_EXTH : PH_PAY;
                end
            end
            PH_EXTH: begin
                // Extension length word sits at the third and fourth extension bytes.
                if (r_byte_cnt == {8'b0, ext_pos + 8'd2}) begin
                    n_skip = {i_byte, 10'b0};
                end else if (r_byte_cnt == {8'b0, ext_pos + 8'd3}) begin
                    n_skip  = skip_new;
                    n_phase = (skip_new != '0) ? PH_SKIP : PH_PAY;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 18'd1;
                if (n_skip == '0) begin
                    n_phase = PH_PAY;
                end
            end
            default: begin
                pay_v = 1'b1;
                if (r_pay_cnt != 17'h1FFFF) begin
                    n_pay_cnt = r_pay_cnt + 17'd1;
                end
            end
        endcase

        if (r_byte_cnt != 16'hFFFF) begin
            n_byte_cnt = r_byte_cnt + 16'd1;
        end

        // Packet end: checks in priority order on the freshly parsed values.
        if (i_last) begin
            if (n_pkt_status == ST_BAD_VERSION) begin
                st = ST_BAD_VERSION;
            end else if (n_phase == PH_B1) begin
                n_sticky = 1'b1;
                st       = ST_LENGTH;
            end else if (n_pkt_status == ST_PT_MISMATCH) begin
                n_frame_fill = '0;
                rs           = 1'b1;
                st           = ST_PT_MISMATCH;
            end else begin
                // A pending error drops the partial frame before later checks.
                if (r_sticky) begin
                    n_sticky = 1'b0;
                    fill0    = '0;
                    rs       = 1'b1;
                end
                n_frame_fill = fill0;
                if (n_pkt_status == ST_RTCP) begin
                    st = ST_RTCP;
                end else if (n_phase != PH_PAY || n_pay_cnt == '0 ||
                             n_pay_cnt > {1'b0, i_cfg.max_payload_len}) begin
                    n_sticky = 1'b1;
                    st       = ST_LENGTH;
                end else begin
                    gap        = (r_prev_seq != '0) && (n_cur_seq != r_prev_seq + 16'd1);
                    n_prev_seq = n_cur_seq;
                    if (gap) begin
                        n_sticky      = 1'b1;
                        n_prev_marker = n_cur_marker;
                        st            = ST_SEQ_GAP;
                    end else begin
                        if (r_prev_marker) begin
                            fill0 = '0;
                            rs    = 1'b1;
                        end
                        n_prev_marker = n_cur_marker;
                        fill_sum      = {1'b0, fill0} + {5'b0, n_pay_cnt};
                        n_frame_fill  = fill0;
                        if (fill_sum > {1'b0, lim}) begin
                            n_sticky = 1'b1;
                            st       = ST_OVERFLOW;
                        end else if (n_cur_marker) begin
                            n_frame_cnt  = r_frame_cnt + 32'd1;
                            fl           = fill_sum[20:0];
                            st           = ST_FRAME_DONE;
                            n_frame_fill = '0;
                        end else begin
                            n_frame_fill = fill_sum[20:0];
                        end
                    end
                end
            end
        end

        // Result items for this byte.
        pay_res.kind          = KIND_PAYLOAD;
        pay_res.payload_byte  = i_byte;
        pay_res.status        = ST_ACCEPTED;
        pay_res.frame_restart = 1'b0;
        pay_res.frame_length  = '0;
        pay_res.frame_number  = '0;
        pay_res.seq_number    = n_cur_seq;
        pay_res.last          = !i_last;

        stat_res.kind          = KIND_STATUS;
        stat_res.payload_byte  = '0;
        stat_res.status        = st;
        stat_res.frame_restart = rs;
        stat_res.frame_length  = fl;
        stat_res.frame_number  = n_frame_cnt;
        stat_res.seq_number    = n_cur_seq;
        stat_res.last          = 1'b1;

        // The per-packet state starts over after the final byte.
        if (i_last) begin
            n_phase      = PH_B0;
            n_byte_cnt   = '0;
            n_csrc       = '0;
            n_ext        = 1'b0;
            n_skip       = '0;
            n_cur_seq    = '0;
            n_cur_marker = 1'b0;
            n_pkt_status = ST_ACCEPTED;
            n_pay_cnt    = '0;
        end
    end

    // Result items handed to the queue.
    always_comb begin
        o_push.valid0 = i_valid && (pay_v || i_last);
        o_push.valid1 = i_valid && pay_v && i_last;
        o_push.res0   = pay_v ? pay_res : stat_res;
        o_push.res1   = stat_res;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_B0;
            r_byte_cnt    <= '0;
            r_csrc        <= '0;
            r_ext         <= 1'b0;
            r_skip        <= '0;
            r_cur_seq     <= '0;
            r_cur_marker  <= 1'b0;
            r_pkt_status  <= ST_ACCEPTED;
            r_pay_cnt     <= '0;
            r_prev_seq    <= '0;
            r_prev_marker <= 1'b0;
            r_sticky      <= 1'b0;
            r_frame_fill  <= '0;
            r_frame_cnt   <= '0;
        end else if (i_valid) begin
            r_phase       <= n_phase;
            r_byte_cnt    <= n_byte_cnt;
            r_csrc        <= n_csrc;
            r_ext         <= n_ext;
            r_skip        <= n_skip;
            r_cur_seq     <= n_cur_seq;
            r_cur_marker  <= n_cur_marker;
            r_pkt_status  <= n_pkt_status;
            r_pay_cnt     <= n_pay_cnt;
            r_prev_seq    <= n_prev_seq;
            r_prev_marker <= n_prev_marker;
            r_sticky      <= n_sticky;
            r_frame_fill  <= n_frame_fill;
            r_frame_cnt   <= n_frame_cnt;
        end
    end

    // The final byte of a packet always returns the parser to the first header byte.
    `RTPD_ASSERT_NEXT(a_pkt_end_restart, i_clk, i_rst_n, i_valid && i_last, r_phase == PH_B0 && r_byte_cnt == '0)
    // Length, gap and overflow errors leave the sticky error set.
    `RTPD_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, i_valid && i_last && (st == ST_LENGTH || st == ST_SEQ_GAP || st == ST_OVERFLOW), r_sticky)
    // A completed frame holds at least the payload of its closing packet.
    `RTPD_ASSERT(a_frame_len_nonzero, i_clk, i_rst_n, (i_valid && i_last && st == ST_FRAME_DONE) |-> (fl != '0))

endmodule

// File: hw/rtl/rtpd_out_queue.sv
// Result queue: takes up to two result items a cycle, hands out one a cycle when popped.
// Depends on rtpd_pkg and on the assertion macros header.
`include "rtp_receive_depacketizer_top_assert.svh"

module rtpd_out_queue
    import rtpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_result o_head,
    output logic    o_nonempty,
    output logic    o_room
);

    t_result              r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [OQ_CNT_W-1:0]  r_count;
    logic [OQ_CNT_W-1:0]  push_n;
    logic                 pop_ok;
    logic [OQ_PTR_W-1:0]  wr_ptr1;

    assign push_n  = OQ_CNT_W'(i_push.valid0) + OQ_CNT_W'(i_push.valid1);
    assign pop_ok  = i_pop && (r_count != '0);
    assign wr_ptr1 = r_wr_ptr + OQ_PTR_W'(1);

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[OQ_PTR_W-1:0];
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + OQ_PTR_W'(1);
            end
            r_count <= r_count + push_n - OQ_CNT_W'(pop_ok);
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    // Room for the item held in the input register and one more just accepted.
    assign o_room     = (r_count <= OQ_CNT_W'(OQ_DEPTH - 4));

    // Writes never land on entries that are still waiting.
    `RTPD_ASSERT(a_no_overflow, i_clk, i_rst_n, ({1'b0, r_count} + {1'b0, push_n}) <= ((OQ_CNT_W + 1)'(OQ_DEPTH) + (OQ_CNT_W + 1)'(pop_ok)))
    // The fill count stays within the storage.
    `RTPD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= OQ_CNT_W'(OQ_DEPTH))

endmodule

// File: hw/rtl/rtp_receive_depacketizer_top.sv
// Each accepted byte passes the input register, then its results go into the result queue.
// Throughput: one item per cycle while s_tready is high; a final payload byte yields
// a second result item; the eight-entry queue drains one per cycle while m_tready is high.
// s_tready falls while the result queue holds more than four items.
// Reset: synchronous, active low; clears control state and restores register defaults.
// Top level of the RTP receive depacketizer; depends on rtpd_pkg and the submodules.
module rtp_receive_depacketizer_top
    import rtpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Packet byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] payload_byte, [10:8] status, [11] frame_restart,
                                   // [32:12] frame_length, [64:33] frame_number,
                                   // [80:65] seq_number, [87:81] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast,   // last
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data
);

    t_cfg       cfg;
    t_push      push;
    t_result    head;
    logic       q_nonempty;
    logic       q_room;
    logic       in_accept;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    rtpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register.
    assign s_tready  = q_room;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    rtpd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (r_in_valid),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_push  (push)
    );

    rtpd_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (m_tready),
        .o_head     (head),
        .o_nonempty (q_nonempty),
        .o_room     (q_room)
    );

    // Result stream packing.
    assign m_tvalid = q_nonempty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {7'b0, head.seq_number, head.frame_number, head.frame_length,
                       head.frame_restart, head.status, head.payload_byte};

endmodule
